[rtl/core/md5_pkg.sv]
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } md5_state_t;

  typedef struct packed {
    logic       wr_byte;
    logic [7:0] wr_data;
    logic       pad_byte;
    logic       init_work;
    logic       round_step;
    logic       fold;
    logic       reinit;
    logic       len_load;
    logic       len_write;
  } md5_cmd_t;

  typedef struct packed {
    logic       pos_wrap;
    logic [5:0] pos;
    logic       last_round;
  } md5_stat_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  function automatic logic [31:0] sine_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] idx);
    logic [4:0] r;
    unique case ({idx[5:4], idx[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/md5_datapath.sv]
module md5_datapath (
  input  logic            clk,
  input  md5_pkg::md5_cmd_t  cmd,
  output md5_pkg::md5_stat_t stat,
  input  logic [1:0]      emit_idx,
  output logic [31:0]     emit_word
);
  import md5_pkg::*;

  logic [31:0] blk_mem [16];
  logic [31:0] chain_r [4];
  logic [31:0] work_r [4];
  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic [31:0] msg_word;
  logic [3:0]  g_idx;
  logic [31:0] f_val, sum_val, rot_val;
  logic [3:0]  i_idx;
  logic [7:0]  wr_val;
  logic        wr_en;

  assign i_idx = rnd_r[3:0];

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: begin
        f_val = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
        g_idx = i_idx;
      end
      2'd1: begin
        f_val = (work_r[1] & work_r[3]) | (work_r[2] & ~work_r[3]);
        g_idx = 4'((5 * i_idx) + 1);
      end
      2'd2: begin
        f_val = work_r[1] ^ work_r[2] ^ work_r[3];
        g_idx = 4'((3 * i_idx) + 5);
      end
      default: begin
        f_val = work_r[2] ^ (work_r[1] | ~work_r[3]);
        g_idx = 4'(7 * i_idx);
      end
    endcase
  end

  assign msg_word = blk_mem[g_idx];
  assign sum_val  = work_r[0] + f_val + msg_word + sine_k(rnd_r);
  assign rot_val  = (sum_val << rot_amt(rnd_r)) | (sum_val >> (6'd32 - {1'b0, rot_amt(rnd_r)}));

  assign wr_en  = cmd.wr_byte | cmd.pad_byte;
  assign wr_val = cmd.wr_byte ? cmd.wr_data : (cmd.len_load ? PAD_MARK : 8'h00);

  // Block bytes: write one byte lane, or the length in the last two words.
  always_ff @(posedge clk) begin
    if (wr_en && !cmd.len_write) begin
      blk_mem[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= wr_val;
    end
    if (cmd.len_write) begin
      blk_mem[14] <= len_r[31:0];
      blk_mem[15] <= len_r[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reinit) begin
      chain_r[0] <= INIT_A; chain_r[1] <= INIT_B;
      chain_r[2] <= INIT_C; chain_r[3] <= INIT_D;
      work_r[0] <= '0; work_r[1] <= '0; work_r[2] <= '0; work_r[3] <= '0;
      pos_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.wr_byte) begin
        len_r <= len_r + 64'd8;
      end
      if (wr_en) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.init_work) begin
        work_r <= chain_r;
        rnd_r <= '0;
      end else if (cmd.round_step) begin
        work_r[0] <= work_r[3];
        work_r[3] <= work_r[2];
        work_r[2] <= work_r[1];
        work_r[1] <= work_r[1] + rot_val;
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.fold) begin
        for (int k = 0; k < 4; k++) begin
          chain_r[k] <= chain_r[k] + work_r[k];
        end
      end
    end
  end

  assign stat.pos        = pos_r;
  assign stat.pos_wrap   = (pos_r == 6'd63);
  assign stat.last_round = (rnd_r == 6'd63);
  assign emit_word       = chain_r[emit_idx];

endmodule

[rtl/core/md5_ctrl.sv]
module md5_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  input  logic               in_has,
  input  logic               in_eom,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         emit_idx,
  output md5_pkg::md5_cmd_t  cmd,
  input  md5_pkg::md5_stat_t stat
);
  import md5_pkg::*;

  md5_state_t state_r, state_nxt;
  logic       closing_r, closing_nxt;
  logic       marked_r, marked_nxt;
  logic       last_r, last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       seeded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      closing_r <= 1'b0;
      marked_r  <= 1'b0;
      last_r    <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      closing_r <= closing_nxt;
      marked_r  <= marked_nxt;
      last_r    <= last_nxt;
      idx_r     <= idx_nxt;
    end
  end

  assign seeded = !rst_n;

  always_comb begin
    state_nxt   = state_r;
    closing_nxt = closing_r;
    marked_nxt  = marked_r;
    last_nxt    = last_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.reinit  = seeded;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.wr_byte = in_has;
          cmd.wr_data = in_byte;
          closing_nxt = in_eom;
          marked_nxt  = 1'b0;
          last_nxt    = 1'b0;
          if (in_has && stat.pos_wrap) begin
            cmd.init_work = 1'b1;
            state_nxt = ST_ROUND;
          end else if (in_eom) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (stat.last_round) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!closing_r) begin
          state_nxt = ST_IDLE;
        end else if (last_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        // First pad byte is the marker, the rest zero; length lands at the end.
        cmd.pad_byte  = 1'b1;
        cmd.len_load  = !marked_r;
        cmd.len_write = stat.pos_wrap && last_r;
        marked_nxt    = 1'b1;
        // Marker already placed before the length field: this block is the last.
        if (stat.pos == LEN_POS && marked_r) begin
          last_nxt = 1'b1;
        end
        if (stat.pos_wrap) begin
          cmd.init_work = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      default: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            cmd.reinit  = 1'b1;
            closing_nxt = 1'b0;
            last_nxt    = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
    endcase
  end

  assign emit_idx = idx_r;

`ifndef SYNTHESIS
  ast_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  ast_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open during emit");
  ast_round_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && stat.last_round) |=> state_r == ST_FOLD)
    else $error("round loop overran");
`endif

endmodule

[rtl/core/md5_message_digest.sv]
// Channel | Dir | tdata                         | tuser
// in_     | in  | [7:0] data_byte               | [0] has_byte; tlast = end_of_message
// out_    | out | [31:0] digest_word            | [1:0] word_index; tlast = last_word
// A byte that neither fills a block nor closes the message leaves in_tready high.
// A byte that completes a block runs 64 rounds of the shared
// step unit, one fold and the return to accept.
// Closing a message writes each pad byte and compresses each pad block,
// then four digest transfers, each held until out_tready.
// Reset (rst_n low, synchronous) loads the initial chaining words.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast
);
  import md5_pkg::*;

  md5_cmd_t   cmd;
  md5_stat_t  stat;
  logic [1:0] emit_idx;
  logic       in_fire;

  assign in_fire = in_tvalid & in_tready;

  md5_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_byte(in_tdata),
    .in_has(in_tuser), .in_eom(in_tlast), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .emit_idx(emit_idx),
    .cmd(cmd), .stat(stat)
  );

  md5_datapath u_dp (
    .clk(clk), .cmd(cmd), .stat(stat), .emit_idx(emit_idx), .emit_word(out_tdata)
  );

  assign out_tuser = emit_idx;
  assign out_tlast = (emit_idx == 2'd3);

endmodule

[verif/md5_message_digest_tb.sv]
module md5_message_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic [31:0] SINE_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int ROT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
  localparam logic [31:0] IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] has_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] digest_word
  logic [1:0]  out_tuser;       // [1:0] word_index
  logic        out_tlast;

  md5_message_digest DUT (.*);

  always #4 clk = ~clk;

  // digest predictor state
  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [5:0]  pos;
  logic [63:0] bit_len;

  msg_item_t    pending_msgs [$];
  digest_item_t expected_digest [$];
  int  mismatches = 0;
  longint cycles = 0;
  bit  hold_send = 1'b0;
  bit  stimulus_done = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] a, b, c, d, f, m;
    int g, st, i;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      st = r / 16; i = r % 16;
      case (st)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      m = {blk[4*g+3], blk[4*g+2], blk[4*g+1], blk[4*g]};
      f = a + f + m + SINE_TAB[r];
      a = d; d = c; c = b;
      b = b + rotl(f, ROT_TAB[st*4 + (i % 4)]);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic clear_digest();
    for (int k = 0; k < 4; k++) chain[k] = IV[k];
    pos = '0;
    bit_len = '0;
  endtask

  task automatic predict_digest(msg_item_t it);
    logic [63:0] len;
    if (it.has_byte) begin
      blk[pos] = it.data_byte;
      bit_len += 64'd8;
      pos++;
      if (pos == 0) compress();
    end
    if (it.end_of_message) begin
      len = bit_len;
      blk[pos] = 8'h80;
      pos++;
      if (pos == 0 || pos > 56) begin
        while (pos != 0) begin
          blk[pos] = 8'h00;
          pos++;
        end
        compress();
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      for (int k = 0; k < 8; k++) blk[56 + k] = len[8*k +: 8];
      compress();
      for (int k = 0; k < 4; k++)
        expected_digest.push_back('{chain[k], 2'(k), k == 3});
      clear_digest();
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_digest('{in_tdata, in_tuser, in_tlast});
        void'(pending_msgs.pop_front());
        send_gap <= $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
        in_tvalid <= 1'b0;
      end else if (!in_tvalid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_msgs.size() > 0 && !(hold_send && expected_digest.size() > 0)) begin
          in_tvalid <= 1'b1;
          {in_tdata, in_tuser, in_tlast} <= pending_msgs[0];
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_digest.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest transfer %h", out_tdata);
        end else begin
          digest_item_t exp_d;
          exp_d = expected_digest.pop_front();
          if (out_tdata !== exp_d.digest_word || out_tuser !== exp_d.word_index ||
              out_tlast !== exp_d.last_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       exp_d.digest_word, exp_d.word_index, exp_d.last_word,
                       out_tdata, out_tuser, out_tlast);
          end
        end
        recv_gap = $urandom_range(0, 9) * ($urandom_range(0, 2) != 0);
        out_tready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= (recv_gap == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] b, bit last);
    pending_msgs.push_back('{b, 1'b1, last});
  endtask

  task automatic add_random_msg(int n);
    bit closed;
    closed = 1'b0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) pending_msgs.push_back('{8'($urandom), 1'b0, 1'b0});
      closed = (k == n - 1) && ($urandom_range(0, 1) != 0);
      add_byte(8'($urandom), closed);
    end
    if (!closed)
      pending_msgs.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  initial begin
    int n;
    clear_digest();
    for (int k = 0; k < 64; k++) blk[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // empty message, idle items, extreme bytes with close on the byte
    pending_msgs.push_back('{8'hff, 1'b0, 1'b0});
    pending_msgs.push_back('{8'h00, 1'b0, 1'b1});
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b1);
    add_byte(8'h55, 1'b0);
    add_byte(8'haa, 1'b0);
    pending_msgs.push_back('{8'h00, 1'b0, 1'b1});
    while (pending_msgs.size() > 0) @(posedge clk);
    hold_send = 1'b1;
    // lengths on either side of the pad boundary: 55 and 56 bytes
    add_random_msg(55);
    add_random_msg(56);
    while (pending_msgs.size() > 0 || expected_digest.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    for (int t = 0; t < 4; t++) begin
      n = $urandom_range(0, 12);
      add_random_msg(n);
    end
    stimulus_done = 1'b1;
    while (pending_msgs.size() > 0 || in_tvalid || expected_digest.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_digest.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
